// ===== hdl/plc_pkg.sv =====
package plc_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] REG_MODE1    = 8'h00;
  localparam logic [7:0] REG_MODE2    = 8'h01;
  localparam logic [7:0] REG_CH_BASE  = 8'h06;
  localparam logic [7:0] REG_ALL_BASE = 8'hFA;
  localparam logic [7:0] REG_ALL_LAST = 8'hFD;
  localparam logic [7:0] REG_PRESCALE = 8'hFE;

  localparam logic [1:0] BYTE_ON_L  = 2'd0;
  localparam logic [1:0] BYTE_ON_H  = 2'd1;
  localparam logic [1:0] BYTE_OFF_L = 2'd2;
  localparam logic [1:0] BYTE_OFF_H = 2'd3;

  localparam int         BIT_RESTART  = 7;
  localparam int         BIT_SLEEP    = 4;
  localparam int         BIT_INVRT    = 4;
  localparam int         BIT_FULL     = 4;
  localparam logic [7:0] MIN_PRESCALE = 8'd3;
  localparam logic [7:0] PRESCALE_RST = 8'h1E;
  localparam logic [7:0] MODE1_RST    = 8'h11;
  localparam logic [4:0] MODE2_RST    = 5'h04;
  localparam logic [4:0] FULL_OFF_RST = 5'h10;

  localparam int PHASE_MAX_W = 16;
  localparam int OUT_W       = 16;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    logic [7:0] data;
  } chan_wr_t;

  typedef struct packed {
    logic [7:0] on_l;
    logic [4:0] on_h;
    logic [7:0] off_l;
    logic [4:0] off_h;
  } chan_regs_t;

  function automatic logic chan_level(input chan_regs_t r,
                                      input logic [PHASE_MAX_W-1:0] phase);
    logic [PHASE_MAX_W-1:0] on;
    logic [PHASE_MAX_W-1:0] off;
    logic                   lvl;
    on  = PHASE_MAX_W'({r.on_h[3:0], r.on_l});
    off = PHASE_MAX_W'({r.off_h[3:0], r.off_l});
    if (r.off_h[BIT_FULL]) begin
      lvl = 1'b0;
    end else if (r.on_h[BIT_FULL]) begin
      lvl = 1'b1;
    end else if (on < off) begin
      lvl = (phase >= on) && (phase < off);
    end else if (on > off) begin
      lvl = (phase >= on) || (phase < off);
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

endpackage

// ===== hdl/plc_timebase.sv =====
module plc_timebase #(
  parameter int COUNTER_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tick,
  input  logic [7:0]              prescale,
  output logic [COUNTER_BITS-1:0] phase_next
);

  logic [7:0]              divider;
  logic [7:0]              divider_next;
  logic [COUNTER_BITS-1:0] phase;

  always_comb begin
    divider_next = divider;
    phase_next   = phase;
    if (tick) begin
      if (divider >= prescale) begin
        divider_next = 8'd0;
        phase_next   = phase + COUNTER_BITS'(1);
      end else begin
        divider_next = divider + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= 8'd0;
      phase   <= '0;
    end else begin
      divider <= divider_next;
      phase   <= phase_next;
    end
  end

endmodule

// ===== hdl/plc_channel.sv =====
module plc_channel (
  input  logic                                clk,
  input  logic                                rst,
  input  plc_pkg::chan_wr_t                   wr,
  input  logic [plc_pkg::PHASE_MAX_W-1:0]     phase,
  output plc_pkg::chan_regs_t                 regs,
  output logic                                level
);

  plc_pkg::chan_regs_t regs_next;

  always_comb begin
    regs_next = regs;
    if (wr.en) begin
      case (wr.sel)
        plc_pkg::BYTE_ON_L:  regs_next.on_l  = wr.data;
        plc_pkg::BYTE_ON_H:  regs_next.on_h  = wr.data[4:0];
        plc_pkg::BYTE_OFF_L: regs_next.off_l = wr.data;
        plc_pkg::BYTE_OFF_H: regs_next.off_h = wr.data[4:0];
        default:             regs_next = regs;
      endcase
    end
  end

  assign level = plc_pkg::chan_level(regs_next, phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.on_l  <= 8'd0;
      regs.on_h  <= 5'd0;
      regs.off_l <= 8'd0;
      regs.off_h <= plc_pkg::FULL_OFF_RST;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

// ===== hdl/pwm_led_controller_16ch.sv =====
// Channel  | Handshake         | Payload
// request  | in_valid/in_stall | command, reg_address, write_data
// result   | out_valid/out_stall | read_data, pwm_outputs, access_error
//
// One request is accepted per cycle while in_stall is low; each gives one result.
// The request is held in an input register and processed in one pass into
// the result register, which also updates the register file and phase counter.
// A stalled result holds the pass, and the input register then stalls requests.
// Synchronous reset restores control, phase, valid flags and full-off channels.
module pwm_led_controller_16ch #(
  parameter int CHANNELS     = 16,
  parameter int COUNTER_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  reg_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [15:0] pwm_outputs,
  output logic        access_error
);

  localparam logic [8:0] CH_END = 9'(32'(plc_pkg::REG_CH_BASE) + 4 * CHANNELS);

  logic                    req_valid;
  logic [1:0]              req_cmd;
  logic [7:0]              req_addr;
  logic [7:0]              req_data;
  logic                    advance;
  logic                    accept;

  logic [7:0]              mode_one;
  logic [7:0]              mode_one_next;
  logic [4:0]              mode_two;
  logic [4:0]              mode_two_next;
  logic [7:0]              prescale;
  logic [7:0]              prescale_next;

  logic                    is_write;
  logic                    is_read;
  logic                    chan_hit;
  logic                    all_hit;
  logic [7:0]              pos;
  logic [1:0]              all_sel;
  logic                    tick_en;
  logic [COUNTER_BITS-1:0] phase_next;
  logic [CHANNELS-1:0]     levels;
  logic [7:0]              chan_byte;
  logic [7:0]              rd_next;
  logic                    err_next;
  logic [15:0]             pwm_next;

  plc_pkg::chan_regs_t     regs [CHANNELS];
  plc_pkg::chan_wr_t       wr   [CHANNELS];

  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd  <= command;
      req_addr <= reg_address;
      req_data <= write_data;
    end
  end

  assign is_write = advance && (req_cmd == plc_pkg::CMD_WRITE);
  assign is_read  = req_cmd == plc_pkg::CMD_READ;
  assign pos      = req_addr - plc_pkg::REG_CH_BASE;
  assign chan_hit = (req_addr >= plc_pkg::REG_CH_BASE) && ({1'b0, req_addr} < CH_END);
  assign all_hit  = (req_addr >= plc_pkg::REG_ALL_BASE) &&
                    (req_addr <= plc_pkg::REG_ALL_LAST);
  assign all_sel  = req_addr[1:0] - plc_pkg::REG_ALL_BASE[1:0];
  assign tick_en  = advance && (req_cmd == plc_pkg::CMD_TICK) &&
                    !mode_one[plc_pkg::BIT_SLEEP];

  plc_timebase #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_timebase (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_en),
    .prescale  (prescale),
    .phase_next(phase_next)
  );

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    always_comb begin
      wr[ch].en   = is_write && (all_hit || (chan_hit && (pos[7:2] == 6'(ch))));
      wr[ch].sel  = all_hit ? all_sel : pos[1:0];
      wr[ch].data = req_data;
    end

    plc_channel u_channel (
      .clk  (clk),
      .rst  (rst),
      .wr   (wr[ch]),
      .phase(plc_pkg::PHASE_MAX_W'(phase_next)),
      .regs (regs[ch]),
      .level(levels[ch])
    );
  end

  always_comb begin
    chan_byte = 8'd0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (pos[7:2] == 6'(ch)) begin
        case (pos[1:0])
          plc_pkg::BYTE_ON_L:  chan_byte = regs[ch].on_l;
          plc_pkg::BYTE_ON_H:  chan_byte = {3'd0, regs[ch].on_h};
          plc_pkg::BYTE_OFF_L: chan_byte = regs[ch].off_l;
          plc_pkg::BYTE_OFF_H: chan_byte = {3'd0, regs[ch].off_h};
          default:             chan_byte = 8'd0;
        endcase
      end
    end
  end

  always_comb begin
    mode_one_next = mode_one;
    mode_two_next = mode_two;
    prescale_next = prescale;
    rd_next       = 8'd0;
    err_next      = 1'b0;
    if (req_cmd == plc_pkg::CMD_WRITE) begin
      if (req_addr == plc_pkg::REG_MODE1) begin
        mode_one_next[6:0] = req_data[6:0];
        if (req_data[plc_pkg::BIT_SLEEP] && !mode_one[plc_pkg::BIT_SLEEP]) begin
          mode_one_next[plc_pkg::BIT_RESTART] = 1'b1;
        end else if (req_data[plc_pkg::BIT_RESTART]) begin
          mode_one_next[plc_pkg::BIT_RESTART] = 1'b0;
        end
      end else if (req_addr == plc_pkg::REG_MODE2) begin
        mode_two_next = req_data[4:0];
      end else if (chan_hit || all_hit) begin
        err_next = 1'b0;
      end else if (req_addr == plc_pkg::REG_PRESCALE) begin
        if (!mode_one[plc_pkg::BIT_SLEEP]) begin
          err_next = 1'b1;
        end else begin
          prescale_next = (req_data < plc_pkg::MIN_PRESCALE) ? plc_pkg::MIN_PRESCALE
                                                             : req_data;
        end
      end else begin
        err_next = 1'b1;
      end
    end else if (is_read) begin
      if (req_addr == plc_pkg::REG_MODE1) begin
        rd_next = mode_one;
      end else if (req_addr == plc_pkg::REG_MODE2) begin
        rd_next = {3'd0, mode_two};
      end else if (chan_hit) begin
        rd_next = chan_byte;
      end else if (all_hit) begin
        rd_next = 8'd0;
      end else if (req_addr == plc_pkg::REG_PRESCALE) begin
        rd_next = prescale;
      end else begin
        err_next = 1'b1;
      end
    end
  end

  assign pwm_next = plc_pkg::OUT_W'(levels ^ {CHANNELS{mode_two_next[plc_pkg::BIT_INVRT]}});

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one <= plc_pkg::MODE1_RST;
      mode_two <= plc_pkg::MODE2_RST;
      prescale <= plc_pkg::PRESCALE_RST;
    end else if (advance) begin
      mode_one <= mode_one_next;
      mode_two <= mode_two_next;
      prescale <= prescale_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= rd_next;
      pwm_outputs  <= pwm_next;
      access_error <= err_next;
    end
  end

endmodule

// ===== hdl/plc_checker.sv =====
module plc_checker #(
  parameter int CHANNELS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic [15:0] pwm_outputs,
  input logic        access_error
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result dropped while stalled.");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> read_data == 8'd0)
    else $error("Failed access returned data.");

  a_unused_channels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_outputs >> CHANNELS) == 16'd0)
    else $error("Output bit of an absent channel is set.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result present after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Requests stalled without a stalled result.");

endmodule

bind pwm_led_controller_16ch plc_checker #(
  .CHANNELS(CHANNELS)
) u_plc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_data   (read_data),
  .pwm_outputs (pwm_outputs),
  .access_error(access_error)
);

// ===== test/tb_pwm_led_controller_16ch.sv =====
`timescale 1ns / 1ps

module tb_pwm_led_controller_16ch;

  localparam int         NUM_CH            = 16;
  localparam int         STORE_BYTES       = 4 * NUM_CH;
  localparam logic [1:0] CMD_NONE          = 2'd3;
  localparam logic [7:0] REG_UNMAPPED_LOW  = 8'h02;
  localparam logic [7:0] REG_UNMAPPED_HIGH = 8'hFF;
  localparam logic [7:0] MODE1_SLEEP       = 8'(1 << plc_pkg::BIT_SLEEP);
  localparam logic [7:0] MODE1_RESTART     = 8'(1 << plc_pkg::BIT_RESTART);

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] levels;
    logic        bad_access;
  } led_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = plc_pkg::CMD_READ;
  logic [7:0]  reg_address = 8'h00;
  logic [7:0]  write_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [15:0] pwm_outputs;
  logic        access_error;

  logic [7:0]  mode1_q;
  logic [7:0]  mode2_q;
  logic [7:0]  prescale_q;
  logic [7:0]  chan_bytes [STORE_BYTES];
  logic [7:0]  divider_q;
  logic [11:0] phase_q;

  led_status_t pending_status [$];
  int          mismatch_count = 0;
  int          requests_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left = 0;

  pwm_led_controller_16ch u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .reg_address  (reg_address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .pwm_outputs  (pwm_outputs),
    .access_error (access_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] chan_addr(int ch, logic [1:0] sel);
    return 8'(int'(plc_pkg::REG_CH_BASE) + 4 * ch + int'(sel));
  endfunction

  function automatic logic [7:0] trim_byte(logic [1:0] sel, logic [7:0] data);
    return sel[0] ? {3'b000, data[4:0]} : data;
  endfunction

  function automatic void reset_led_state();
    mode1_q    = plc_pkg::MODE1_RST;
    mode2_q    = {3'b000, plc_pkg::MODE2_RST};
    prescale_q = plc_pkg::PRESCALE_RST;
    for (int i = 0; i < STORE_BYTES; i++) begin
      chan_bytes[i] = (i % 4 == int'(plc_pkg::BYTE_OFF_H)) ?
                      {3'b000, plc_pkg::FULL_OFF_RST} : 8'h00;
    end
    divider_q = 8'h00;
    phase_q   = 12'h000;
  endfunction

  function automatic logic write_register(logic [7:0] addr, logic [7:0] data);
    logic restart;
    int   idx;
    if (addr == plc_pkg::REG_MODE1) begin
      restart = mode1_q[plc_pkg::BIT_RESTART];
      if (data[plc_pkg::BIT_RESTART]) restart = 1'b0;
      if (data[plc_pkg::BIT_SLEEP] && !mode1_q[plc_pkg::BIT_SLEEP]) restart = 1'b1;
      mode1_q = {restart, data[6:0]};
      return 1'b0;
    end
    if (addr == plc_pkg::REG_MODE2) begin
      mode2_q = {3'b000, data[4:0]};
      return 1'b0;
    end
    if (addr >= plc_pkg::REG_CH_BASE &&
        int'(addr) < int'(plc_pkg::REG_CH_BASE) + STORE_BYTES) begin
      idx = int'(addr) - int'(plc_pkg::REG_CH_BASE);
      chan_bytes[idx] = trim_byte(2'(idx), data);
      return 1'b0;
    end
    if (addr >= plc_pkg::REG_ALL_BASE && addr <= plc_pkg::REG_ALL_LAST) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        chan_bytes[4 * ch + int'(addr - plc_pkg::REG_ALL_BASE)] =
          trim_byte(2'(addr - plc_pkg::REG_ALL_BASE), data);
      end
      return 1'b0;
    end
    if (addr == plc_pkg::REG_PRESCALE) begin
      if (!mode1_q[plc_pkg::BIT_SLEEP]) return 1'b1;
      prescale_q = (data < plc_pkg::MIN_PRESCALE) ? plc_pkg::MIN_PRESCALE : data;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic read_register(logic [7:0] addr, output logic [7:0] data);
    data = 8'h00;
    if (addr == plc_pkg::REG_MODE1) begin
      data = mode1_q;
    end else if (addr == plc_pkg::REG_MODE2) begin
      data = mode2_q;
    end else if (addr >= plc_pkg::REG_CH_BASE &&
                 int'(addr) < int'(plc_pkg::REG_CH_BASE) + STORE_BYTES) begin
      data = chan_bytes[int'(addr) - int'(plc_pkg::REG_CH_BASE)];
    end else if (addr >= plc_pkg::REG_ALL_BASE && addr <= plc_pkg::REG_ALL_LAST) begin
      data = 8'h00;
    end else if (addr == plc_pkg::REG_PRESCALE) begin
      data = prescale_q;
    end else begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_oscillator();
    if (mode1_q[plc_pkg::BIT_SLEEP]) return;
    if (divider_q >= prescale_q) begin
      divider_q = 8'h00;
      phase_q   = phase_q + 12'd1;
    end else begin
      divider_q = divider_q + 8'd1;
    end
  endfunction

  function automatic logic [15:0] channel_levels();
    logic [15:0] lv;
    logic [11:0] on_at;
    logic [11:0] off_at;
    lv = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      on_at  = {chan_bytes[4 * ch + 1][3:0], chan_bytes[4 * ch]};
      off_at = {chan_bytes[4 * ch + 3][3:0], chan_bytes[4 * ch + 2]};
      if (chan_bytes[4 * ch + 3][plc_pkg::BIT_FULL]) lv[ch] = 1'b0;
      else if (chan_bytes[4 * ch + 1][plc_pkg::BIT_FULL]) lv[ch] = 1'b1;
      else if (on_at < off_at) lv[ch] = (phase_q >= on_at) && (phase_q < off_at);
      else if (on_at > off_at) lv[ch] = (phase_q >= on_at) || (phase_q < off_at);
      else lv[ch] = 1'b0;
    end
    if (mode2_q[plc_pkg::BIT_INVRT]) lv = ~lv;
    return lv;
  endfunction

  function automatic led_status_t apply_request(logic [1:0] cmd, logic [7:0] addr,
                                                logic [7:0] data);
    led_status_t st;
    st = '0;
    case (cmd)
      plc_pkg::CMD_WRITE: st.bad_access = write_register(addr, data);
      plc_pkg::CMD_READ:  st.bad_access = read_register(addr, st.read_byte);
      plc_pkg::CMD_TICK:  advance_oscillator();
      default:   ;
    endcase
    st.levels = channel_levels();
    return st;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    reg_address <= addr;
    write_data  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status.push_back(apply_request(cmd, addr, data));
    requests_sent++;
  endtask

  always @(posedge clk) begin
    led_status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected result", int'(pwm_outputs), 0);
      end else begin
        want = pending_status.pop_front();
        if (read_data !== want.read_byte) begin
          report_mismatch("read_data", int'(read_data), int'(want.read_byte));
        end
        if (pwm_outputs !== want.levels) begin
          report_mismatch("pwm_outputs", int'(pwm_outputs), int'(want.levels));
        end
        if (access_error !== want.bad_access) begin
          report_mismatch("access_error", int'(access_error), int'(want.bad_access));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [11:0] pick_edge();
    if ($urandom_range(7) == 0) return 12'($urandom);
    return phase_q + 12'($urandom_range(96)) - 12'd24;
  endfunction

  task automatic program_channel(logic [7:0] base, logic [11:0] on_at, logic [11:0] off_at,
                                 logic full_on, logic full_off);
    send_request(plc_pkg::CMD_WRITE, base + 8'(plc_pkg::BYTE_ON_L), on_at[7:0]);
    send_request(plc_pkg::CMD_WRITE, base + 8'(plc_pkg::BYTE_ON_H),
                 {3'($urandom), full_on, on_at[11:8]});
    send_request(plc_pkg::CMD_WRITE, base + 8'(plc_pkg::BYTE_OFF_L), off_at[7:0]);
    send_request(plc_pkg::CMD_WRITE, base + 8'(plc_pkg::BYTE_OFF_H),
                 {3'($urandom), full_off, off_at[11:8]});
  endtask

  task automatic random_sequence();
    int          kind;
    logic [7:0]  addr;
    logic [7:0]  ps;
    kind = $urandom_range(99);
    if (kind < 30) begin
      addr = ($urandom_range(7) == 0) ? plc_pkg::REG_ALL_BASE :
             chan_addr($urandom_range(NUM_CH - 1), plc_pkg::BYTE_ON_L);
      program_channel(addr, pick_edge(), pick_edge(), $urandom_range(5) == 0,
                      $urandom_range(5) == 0);
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 40)) begin
        send_request(plc_pkg::CMD_TICK, 8'($urandom), 8'($urandom));
      end
    end else if (kind < 70) begin
      ps = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
      send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, 8'($urandom) | MODE1_SLEEP);
      send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_PRESCALE, ps);
      send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, 8'($urandom) & ~MODE1_SLEEP);
    end else if (kind < 80) begin
      send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE2, 8'($urandom));
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(4))
          0: addr = plc_pkg::REG_MODE1;
          1: addr = plc_pkg::REG_MODE2;
          2: addr = plc_pkg::REG_PRESCALE;
          3: addr = plc_pkg::REG_ALL_BASE + 8'($urandom_range(3));
          default: addr = chan_addr($urandom_range(NUM_CH - 1), 2'($urandom));
        endcase
        send_request(plc_pkg::CMD_READ, addr, 8'($urandom));
      end
    end else begin
      send_request(2'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_values();
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_MODE1, 8'h00);
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_MODE2, 8'h00);
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_PRESCALE, 8'h00);
    send_request(plc_pkg::CMD_READ, chan_addr(0, plc_pkg::BYTE_OFF_H), 8'h00);
    send_request(plc_pkg::CMD_READ, chan_addr(NUM_CH - 1, plc_pkg::BYTE_OFF_H), 8'h00);
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_ALL_BASE, 8'h00);
  endtask

  task automatic test_mode_registers();
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_PRESCALE, 8'h00);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, MODE1_RESTART);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_PRESCALE, 8'hFF);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, 8'hFF);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, 8'h00);
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_MODE1, 8'h00);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE2, 8'hFF);
    send_request(plc_pkg::CMD_READ, plc_pkg::REG_MODE2, 8'h00);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE2, {3'b000, plc_pkg::MODE2_RST});
  endtask

  task automatic test_channel_windows();
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_ALL_LAST, 8'hE0);
    send_request(plc_pkg::CMD_WRITE, chan_addr(0, plc_pkg::BYTE_OFF_L), 8'h02);
    send_request(plc_pkg::CMD_WRITE, chan_addr(1, plc_pkg::BYTE_ON_L), 8'h01);
    send_request(plc_pkg::CMD_WRITE, chan_addr(2, plc_pkg::BYTE_ON_H), 8'hFF);
    send_request(plc_pkg::CMD_WRITE, chan_addr(3, plc_pkg::BYTE_ON_H), 8'h10);
    send_request(plc_pkg::CMD_WRITE, chan_addr(3, plc_pkg::BYTE_OFF_H), 8'h10);
    send_request(plc_pkg::CMD_READ, chan_addr(2, plc_pkg::BYTE_ON_H), 8'h00);
    repeat (10) send_request(plc_pkg::CMD_TICK, 8'h00, 8'h00);
  endtask

  task automatic test_unmapped_access();
    send_request(plc_pkg::CMD_READ, REG_UNMAPPED_LOW, 8'h00);
    send_request(plc_pkg::CMD_WRITE, chan_addr(NUM_CH, plc_pkg::BYTE_ON_L), 8'hA5);
    send_request(plc_pkg::CMD_READ, REG_UNMAPPED_HIGH, 8'h00);
    send_request(CMD_NONE, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = requests_sent;
    while (requests_sent - start < count) random_sequence();
  endtask

  task automatic test_output_backpressure();
    int start;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left <= 80;
    start = requests_sent;
    while (requests_sent - start < 60) random_sequence();
  endtask

  task automatic test_phase_wrap();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, MODE1_SLEEP);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_PRESCALE, 8'h00);
    send_request(plc_pkg::CMD_WRITE, plc_pkg::REG_MODE1, 8'h00);
    program_channel(chan_addr(0, plc_pkg::BYTE_ON_L), phase_q + 12'd20, phase_q + 12'd8,
                    1'b0, 1'b0);
    repeat (100) send_request(plc_pkg::CMD_TICK, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int waited;
    reset_led_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_mode_registers();
    test_channel_windows();
    test_unmapped_access();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 88, 0);
    test_random_traffic(350, 0, 88);
    test_random_traffic(350, 38, 38);
    test_output_backpressure();
    test_phase_wrap();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    waited = 0;
    while (pending_status.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_status.size() > 0) report_mismatch("results left over", pending_status.size(), 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/plc_pkg.sv
hdl/plc_timebase.sv
hdl/plc_channel.sv
hdl/pwm_led_controller_16ch.sv
hdl/plc_checker.sv
test/tb_pwm_led_controller_16ch.sv
